FILE: hw/rtl/mvr_pkg.sv
// Shared types, constants and the CRC-16/X.25 byte update for the MAVLink v1 receiver.
package mvr_pkg;

  localparam int unsigned CAP_DEPTH = 26;
  localparam int unsigned CAP_IDX_W = $clog2(CAP_DEPTH);
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [7:0] START_BYTE   = 8'hFE;
  localparam logic [7:0] CAP_LIMIT    = 8'(CAP_DEPTH);
  localparam logic [7:0] FLOW_LEN     = 8'd26;
  localparam logic [7:0] DIST_LEN     = 8'd14;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] DIST_NONE   = 16'hFFFF;

  localparam logic [7:0] FLOW_ID_RST    = 8'd100;
  localparam logic [7:0] DIST_ID_RST    = 8'd132;
  localparam logic [7:0] FLOW_EXTRA_RST = 8'd175;
  localparam logic [7:0] DIST_EXTRA_RST = 8'd85;

  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_ID    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_ID    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_EXTRA = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_EXTRA = CFG_IDX_W'(3);

  typedef enum logic [3:0] {
    PH_WAIT = 4'd0,
    PH_LEN  = 4'd1,
    PH_SEQ  = 4'd2,
    PH_SYS  = 4'd3,
    PH_COMP = 4'd4,
    PH_MSG  = 4'd5,
    PH_PAY  = 4'd6,
    PH_CRCL = 4'd7,
    PH_CRCH = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_BAD_LEN = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_FLOW  = 2'd0,
    KIND_DIST  = 2'd1,
    KIND_OTHER = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] flow_id;
    logic [7:0] dist_id;
    logic [7:0] flow_extra;
    logic [7:0] dist_extra;
  } cfg_t;

  // A finished frame as the parser hands it to the checker.
  typedef struct packed {
    logic [7:0]  seq;
    logic [7:0]  sys_id;
    logic [7:0]  comp_id;
    logic [7:0]  msg_id;
    logic [7:0]  len;
    logic [15:0] crc_acc;
    logic [15:0] crc_rx;
    logic [15:0] flow_x;
    logic [15:0] flow_y;
    logic [7:0]  quality;
    logic [15:0] dist_cm;
  } frame_t;

  typedef struct packed {
    status_e     status;
    kind_e       kind;
    logic [7:0]  seq;
    logic [7:0]  sys_id;
    logic [7:0]  comp_id;
    logic [7:0]  msg_id;
    logic [15:0] flow_x;
    logic [15:0] flow_y;
    logic [7:0]  quality;
    logic [15:0] dist_cm;
    logic        dist_valid;
  } result_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

FILE: hw/rtl/mavlink_v1_frame_receiver.sv
// Top level of the MAVLink v1 frame receiver: input and result registers around the parser.
//
//   Channel  Direction  Handshake               Payload
//   in       into       in_valid_i/in_stall_o   rx_byte_i
//   out      out of     out_valid_o/out_stall_i frame_status_o .. distance_valid_o
//   cfg      into       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One word is accepted per cycle unless the input stalls; each word waits in the input
// register, and the parse step, CRC update and frame check run between it and the result
// register. A result is written there when its high CRC byte leaves the input register.
// Reset returns the parser to hunting for a start byte and restores the register defaults.
// The input stalls only while its register is full and a waiting result is itself stalled.
module mavlink_v1_frame_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    frame_status_o,
  output logic [1:0]                    message_kind_o,
  output logic [7:0]                    sequence_number_o,
  output logic [7:0]                    system_id_o,
  output logic [7:0]                    component_id_o,
  output logic [7:0]                    message_id_o,
  output logic signed [15:0]            flow_x_o,
  output logic signed [15:0]            flow_y_o,
  output logic [7:0]                    flow_quality_o,
  output logic [15:0]                   distance_cm_o,
  output logic                          distance_valid_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mvr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);

  mvr_pkg::cfg_t    cfg;
  mvr_pkg::frame_t  frame;
  mvr_pkg::result_t result;
  mvr_pkg::result_t res_q;
  logic             res_vld_q, res_vld_d;
  logic [7:0]       byte_q;
  logic             byte_vld_q, byte_vld_d;
  logic             advance;
  logic             accept;
  logic             emit;

  // The parser may step whenever the result register is empty or is being drained.
  assign advance    = !(res_vld_q && out_stall_i);
  assign in_stall_o = byte_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  mvr_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mvr_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (byte_vld_q && advance),
    .byte_i  (byte_q),
    .emit_o  (emit),
    .frame_o (frame)
  );

  mvr_frame_check u_frame_check (
    .cfg_i    (cfg),
    .frame_i  (frame),
    .result_o (result)
  );

  always_comb begin
    byte_vld_d = byte_vld_q;
    if (accept) begin
      byte_vld_d = 1'b1;
    end else if (advance) begin
      byte_vld_d = 1'b0;
    end
    res_vld_d = advance ? emit : res_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      byte_vld_q <= byte_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
    end
    if (advance && emit) begin
      res_q <= result;
    end
  end

  assign out_valid_o       = res_vld_q;
  assign frame_status_o    = res_q.status;
  assign message_kind_o    = res_q.kind;
  assign sequence_number_o = res_q.seq;
  assign system_id_o       = res_q.sys_id;
  assign component_id_o    = res_q.comp_id;
  assign message_id_o      = res_q.msg_id;
  assign flow_x_o          = res_q.flow_x;
  assign flow_y_o          = res_q.flow_y;
  assign flow_quality_o    = res_q.quality;
  assign distance_cm_o     = res_q.dist_cm;
  assign distance_valid_o  = res_q.dist_valid;

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (byte_vld_q && out_valid_o && out_stall_i))
    else $error("input stalled while the pipeline could advance");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(res_q))
    else $error("pending result overwritten or dropped");

  a_fields_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (frame_status_o != mvr_pkg::ST_OK)) |->
      (flow_x_o == 16'sd0 && flow_y_o == 16'sd0 && flow_quality_o == 8'd0 &&
       distance_cm_o == 16'd0 && !distance_valid_o))
    else $error("decoded fields set on a failed frame");

  a_dist_valid_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && distance_valid_o) |->
      (message_kind_o == mvr_pkg::KIND_DIST && frame_status_o == mvr_pkg::ST_OK))
    else $error("distance flagged valid outside an ok distance frame");

endmodule

FILE: hw/rtl/mvr_cfg_regs.sv
// Configuration registers: message ids and CRC extra bytes.
module mvr_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mvr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  output mvr_pkg::cfg_t                  cfg_o
);

  mvr_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mvr_pkg::CFG_FLOW_ID:    cfg_d.flow_id    = cfg_data_i;
        mvr_pkg::CFG_DIST_ID:    cfg_d.dist_id    = cfg_data_i;
        mvr_pkg::CFG_FLOW_EXTRA: cfg_d.flow_extra = cfg_data_i;
        mvr_pkg::CFG_DIST_EXTRA: cfg_d.dist_extra = cfg_data_i;
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flow_id    <= mvr_pkg::FLOW_ID_RST;
      cfg_q.dist_id    <= mvr_pkg::DIST_ID_RST;
      cfg_q.flow_extra <= mvr_pkg::FLOW_EXTRA_RST;
      cfg_q.dist_extra <= mvr_pkg::DIST_EXTRA_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: hw/rtl/mvr_parser.sv
// Frame parser: phase machine, header and payload capture, running CRC.
module mvr_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      byte_i,
  output logic            emit_o,
  output mvr_pkg::frame_t frame_o
);

  mvr_pkg::phase_e phase_q, phase_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [7:0]  hdr_q [4];
  logic [7:0]  hdr_d [4];
  logic [7:0]  cap_q [mvr_pkg::CAP_DEPTH];
  logic        cap_we;
  logic [15:0] crc_next;
  logic [7:0]  cnt_inc;

  assign crc_next = mvr_pkg::crc_fold(crc_q, byte_i);
  assign cnt_inc  = cnt_q + 8'd1;

  // Next state.
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    hdr_d    = hdr_q;
    cap_we   = 1'b0;
    if (step_i) begin
      unique case (phase_q)
        mvr_pkg::PH_WAIT: begin
          if (byte_i == mvr_pkg::START_BYTE) begin
            crc_d   = mvr_pkg::CRC_INIT;
            cnt_d   = 8'd0;
            phase_d = mvr_pkg::PH_LEN;
          end
        end
        mvr_pkg::PH_LEN: begin
          len_d   = byte_i;
          crc_d   = crc_next;
          phase_d = mvr_pkg::PH_SEQ;
        end
        mvr_pkg::PH_SEQ: begin
          hdr_d[0] = byte_i;
          crc_d    = crc_next;
          phase_d  = mvr_pkg::PH_SYS;
        end
        mvr_pkg::PH_SYS: begin
          hdr_d[1] = byte_i;
          crc_d    = crc_next;
          phase_d  = mvr_pkg::PH_COMP;
        end
        mvr_pkg::PH_COMP: begin
          hdr_d[2] = byte_i;
          crc_d    = crc_next;
          phase_d  = mvr_pkg::PH_MSG;
        end
        mvr_pkg::PH_MSG: begin
          hdr_d[3] = byte_i;
          crc_d    = crc_next;
          phase_d  = (len_q == 8'd0) ? mvr_pkg::PH_CRCL : mvr_pkg::PH_PAY;
        end
        mvr_pkg::PH_PAY: begin
          // Bytes past the capture depth still go into the CRC.
          cap_we = (cnt_q < mvr_pkg::CAP_LIMIT);
          crc_d  = crc_next;
          cnt_d  = cnt_inc;
          if (cnt_inc >= len_q) begin
            phase_d = mvr_pkg::PH_CRCL;
          end
        end
        mvr_pkg::PH_CRCL: begin
          crc_lo_d = byte_i;
          phase_d  = mvr_pkg::PH_CRCH;
        end
        mvr_pkg::PH_CRCH: begin
          phase_d = mvr_pkg::PH_WAIT;
          cnt_d   = 8'd0;
          crc_d   = mvr_pkg::CRC_INIT;
        end
        default: phase_d = mvr_pkg::PH_WAIT;
      endcase
    end
  end

  // Outputs.
  always_comb begin
    emit_o          = step_i && (phase_q == mvr_pkg::PH_CRCH);
    frame_o.seq     = hdr_q[0];
    frame_o.sys_id  = hdr_q[1];
    frame_o.comp_id = hdr_q[2];
    frame_o.msg_id  = hdr_q[3];
    frame_o.len     = len_q;
    frame_o.crc_acc = crc_q;
    frame_o.crc_rx  = {byte_i, crc_lo_q};
    frame_o.flow_x  = {cap_q[21], cap_q[20]};
    frame_o.flow_y  = {cap_q[23], cap_q[22]};
    frame_o.quality = cap_q[25];
    frame_o.dist_cm = {cap_q[9], cap_q[8]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= mvr_pkg::PH_WAIT;
      cnt_q    <= 8'd0;
      len_q    <= 8'd0;
      crc_q    <= mvr_pkg::CRC_INIT;
      crc_lo_q <= 8'd0;
      for (int i = 0; i < 4; i++) begin
        hdr_q[i] <= 8'd0;
      end
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
      hdr_q    <= hdr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_we) begin
      cap_q[cnt_q[mvr_pkg::CAP_IDX_W-1:0]] <= byte_i;
    end
  end

endmodule

FILE: hw/rtl/mvr_frame_check.sv
// Frame check: message kind, CRC extra fold, status and decoded fields.
module mvr_frame_check (
  input  mvr_pkg::cfg_t    cfg_i,
  input  mvr_pkg::frame_t  frame_i,
  output mvr_pkg::result_t result_o
);

  mvr_pkg::kind_e kind;
  logic [7:0]     extra;
  logic           crc_ok;

  always_comb begin
    // Optical flow wins when both id registers hold the same value.
    priority if (frame_i.msg_id == cfg_i.flow_id) begin
      kind  = mvr_pkg::KIND_FLOW;
      extra = cfg_i.flow_extra;
    end else if (frame_i.msg_id == cfg_i.dist_id) begin
      kind  = mvr_pkg::KIND_DIST;
      extra = cfg_i.dist_extra;
    end else begin
      kind  = mvr_pkg::KIND_OTHER;
      extra = 8'h00;
    end
  end

  assign crc_ok = (mvr_pkg::crc_fold(frame_i.crc_acc, extra) == frame_i.crc_rx);

  always_comb begin
    result_o.status     = mvr_pkg::ST_OK;
    result_o.kind       = kind;
    result_o.seq        = frame_i.seq;
    result_o.sys_id     = frame_i.sys_id;
    result_o.comp_id    = frame_i.comp_id;
    result_o.msg_id     = frame_i.msg_id;
    result_o.flow_x     = 16'h0000;
    result_o.flow_y     = 16'h0000;
    result_o.quality    = 8'h00;
    result_o.dist_cm    = 16'h0000;
    result_o.dist_valid = 1'b0;
    if (!crc_ok) begin
      result_o.status = mvr_pkg::ST_CRC_ERR;
    end else begin
      unique case (kind)
        mvr_pkg::KIND_FLOW: begin
          if (frame_i.len != mvr_pkg::FLOW_LEN) begin
            result_o.status = mvr_pkg::ST_BAD_LEN;
          end else begin
            result_o.flow_x  = frame_i.flow_x;
            result_o.flow_y  = frame_i.flow_y;
            result_o.quality = frame_i.quality;
          end
        end
        mvr_pkg::KIND_DIST: begin
          if (frame_i.len != mvr_pkg::DIST_LEN) begin
            result_o.status = mvr_pkg::ST_BAD_LEN;
          end else begin
            result_o.dist_cm    = frame_i.dist_cm;
            result_o.dist_valid = (frame_i.dist_cm != mvr_pkg::DIST_NONE);
          end
        end
        default: result_o.status = mvr_pkg::ST_UNKNOWN;
      endcase
    end
  end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the MAVLink v1 frame receiver, predicted byte by byte.
`timescale 1ns / 1ps

module testbench;

  typedef logic [7:0] byte_q_t[$];

  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_BYTES  = 1200;

  logic                          clk_i             = 1'b0;
  logic                          rst_ni            = 1'b0;
  logic                          in_valid_i        = 1'b0;
  logic                          in_stall_o;
  logic [7:0]                    rx_byte_i         = 8'h00;
  logic                          out_valid_o;
  logic                          out_stall_i       = 1'b0;
  logic [1:0]                    frame_status_o;
  logic [1:0]                    message_kind_o;
  logic [7:0]                    sequence_number_o;
  logic [7:0]                    system_id_o;
  logic [7:0]                    component_id_o;
  logic [7:0]                    message_id_o;
  logic signed [15:0]            flow_x_o;
  logic signed [15:0]            flow_y_o;
  logic [7:0]                    flow_quality_o;
  logic [15:0]                   distance_cm_o;
  logic                          distance_valid_o;
  logic                          cfg_valid_i       = 1'b0;
  logic                          cfg_ready_o;
  logic [mvr_pkg::CFG_IDX_W-1:0] cfg_index_i       = '0;
  logic [7:0]                    cfg_data_i        = 8'h00;

  // Parser state as the predictor tracks it.
  mvr_pkg::phase_e parse_phase;
  logic [7:0]      pay_count;
  logic [7:0]      pay_length;
  logic [7:0]      crc_low_byte;
  logic [15:0]     crc_running;
  logic [7:0]      header_q [4];
  logic [7:0]      capture [mvr_pkg::CAP_DEPTH];
  logic [7:0]      flow_id;
  logic [7:0]      dist_id;
  logic [7:0]      flow_extra;
  logic [7:0]      dist_extra;

  mvr_pkg::result_t expected_frames[$];
  int      bytes_parsed = 0;
  int      error_count  = 0;
  int      cycle_count  = 0;
  int      idle_odds    = 0;
  int      stall_left   = 0;

  mavlink_v1_frame_receiver uut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Bit-serial form of the reflected X.25 polynomial.
  function automatic logic [15:0] x25_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int          i;
    c = crc ^ {8'h00, b};
    for (i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    return c;
  endfunction

  function automatic bit predict_byte(input logic [7:0] b, output mvr_pkg::result_t r);
    logic [15:0] rx_crc;
    logic [7:0]  extra;
    r = '0;
    predict_byte = 1'b0;
    case (parse_phase)
      mvr_pkg::PH_WAIT: begin
        if (b == mvr_pkg::START_BYTE) begin
          crc_running = mvr_pkg::CRC_INIT;
          pay_count   = 8'd0;
          parse_phase = mvr_pkg::PH_LEN;
        end
      end
      mvr_pkg::PH_LEN: begin
        pay_length  = b;
        crc_running = x25_update(crc_running, b);
        parse_phase = mvr_pkg::PH_SEQ;
      end
      mvr_pkg::PH_SEQ, mvr_pkg::PH_SYS, mvr_pkg::PH_COMP, mvr_pkg::PH_MSG: begin
        header_q[parse_phase - mvr_pkg::PH_SEQ] = b;
        crc_running = x25_update(crc_running, b);
        if (parse_phase == mvr_pkg::PH_MSG) begin
          parse_phase = (pay_length == 8'd0) ? mvr_pkg::PH_CRCL : mvr_pkg::PH_PAY;
        end else begin
          parse_phase = mvr_pkg::phase_e'(parse_phase + 4'd1);
        end
      end
      mvr_pkg::PH_PAY: begin
        if (pay_count < mvr_pkg::CAP_LIMIT) capture[pay_count] = b;
        crc_running = x25_update(crc_running, b);
        pay_count++;
        if (pay_count >= pay_length) parse_phase = mvr_pkg::PH_CRCL;
      end
      mvr_pkg::PH_CRCL: begin
        crc_low_byte = b;
        parse_phase  = mvr_pkg::PH_CRCH;
      end
      mvr_pkg::PH_CRCH: begin
        rx_crc = {b, crc_low_byte};
        // Flow wins when both id registers hold the same value.
        if (header_q[3] == flow_id) begin
          r.kind = mvr_pkg::KIND_FLOW;
          extra  = flow_extra;
        end else if (header_q[3] == dist_id) begin
          r.kind = mvr_pkg::KIND_DIST;
          extra  = dist_extra;
        end else begin
          r.kind = mvr_pkg::KIND_OTHER;
          extra  = 8'h00;
        end
        r.seq     = header_q[0];
        r.sys_id  = header_q[1];
        r.comp_id = header_q[2];
        r.msg_id  = header_q[3];
        if (x25_update(crc_running, extra) != rx_crc) begin
          r.status = mvr_pkg::ST_CRC_ERR;
        end else if (r.kind == mvr_pkg::KIND_OTHER) begin
          r.status = mvr_pkg::ST_UNKNOWN;
        end else if (r.kind == mvr_pkg::KIND_FLOW) begin
          if (pay_length != mvr_pkg::FLOW_LEN) begin
            r.status = mvr_pkg::ST_BAD_LEN;
          end else begin
            r.status  = mvr_pkg::ST_OK;
            r.flow_x  = {capture[21], capture[20]};
            r.flow_y  = {capture[23], capture[22]};
            r.quality = capture[25];
          end
        end else if (pay_length != mvr_pkg::DIST_LEN) begin
          r.status = mvr_pkg::ST_BAD_LEN;
        end else begin
          r.status     = mvr_pkg::ST_OK;
          r.dist_cm    = {capture[9], capture[8]};
          r.dist_valid = (r.dist_cm != mvr_pkg::DIST_NONE);
        end
        predict_byte = 1'b1;
        parse_phase  = mvr_pkg::PH_WAIT;
        pay_count    = 8'd0;
        crc_running  = mvr_pkg::CRC_INIT;
      end
      default: parse_phase = mvr_pkg::PH_WAIT;
    endcase
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) flag_error($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    mvr_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_frames.size() == 0) begin
        flag_error("result word with no frame pending");
      end else begin
        want = expected_frames.pop_front();
        check_field("frame_status", frame_status_o, want.status);
        check_field("message_kind", message_kind_o, want.kind);
        check_field("sequence_number", sequence_number_o, want.seq);
        check_field("system_id", system_id_o, want.sys_id);
        check_field("component_id", component_id_o, want.comp_id);
        check_field("message_id", message_id_o, want.msg_id);
        check_field("flow_x", flow_x_o, want.flow_x);
        check_field("flow_y", flow_y_o, want.flow_y);
        check_field("flow_quality", flow_quality_o, want.quality);
        check_field("distance_cm", distance_cm_o, want.dist_cm);
        check_field("distance_valid", distance_valid_o, want.dist_valid);
      end
    end
  end

  // Receiver back-pressure in bursts of random length.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      stall_left = $urandom_range(0, 14);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int               gap;
    mvr_pkg::result_t r;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (parse_phase != mvr_pkg::PH_WAIT || b == mvr_pkg::START_BYTE) bytes_parsed++;
    if (predict_byte(b, r)) expected_frames.push_back(r);
  endtask

  // Waits for every pending result, then lets the pipeline settle.
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_frames.size() != 0) begin
      flag_error($sformatf("%0d frames never produced a result", expected_frames.size()));
      expected_frames.delete();
    end
  endtask

  task automatic write_register(input logic [mvr_pkg::CFG_IDX_W-1:0] idx,
                                input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      mvr_pkg::CFG_FLOW_ID:    flow_id    = value;
      mvr_pkg::CFG_DIST_ID:    dist_id    = value;
      mvr_pkg::CFG_FLOW_EXTRA: flow_extra = value;
      mvr_pkg::CFG_DIST_EXTRA: dist_extra = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_registers(input logic [7:0] f_id, input logic [7:0] d_id,
                               input logic [7:0] f_extra, input logic [7:0] d_extra);
    write_register(mvr_pkg::CFG_FLOW_ID, f_id);
    write_register(mvr_pkg::CFG_DIST_ID, d_id);
    write_register(mvr_pkg::CFG_FLOW_EXTRA, f_extra);
    write_register(mvr_pkg::CFG_DIST_EXTRA, d_extra);
  endtask

  function automatic byte_q_t random_payload(input int len);
    byte_q_t p;
    repeat (len) p.push_back(8'($urandom));
    return p;
  endfunction

  function automatic int random_length();
    return ($urandom_range(0, 24) == 0) ? $urandom_range(27, 255) : $urandom_range(0, 30);
  endfunction

  // Builds a frame with a random header and sends all but the last drop_tail bytes.
  task automatic send_frame(input logic [7:0] msg_id, input byte_q_t payload,
                            input bit bad_crc, input int drop_tail);
    byte_q_t     frame;
    logic [15:0] crc;
    logic [7:0]  extra;
    int          i;
    frame.push_back(mvr_pkg::START_BYTE);
    frame.push_back(8'(payload.size()));
    repeat (3) frame.push_back(8'($urandom));
    frame.push_back(msg_id);
    foreach (payload[j]) frame.push_back(payload[j]);
    crc = mvr_pkg::CRC_INIT;
    for (i = 1; i < frame.size(); i++) crc = x25_update(crc, frame[i]);
    if (msg_id == flow_id) extra = flow_extra;
    else if (msg_id == dist_id) extra = dist_extra;
    else extra = 8'h00;
    crc = x25_update(crc, extra);
    if (bad_crc) crc ^= 16'($urandom_range(1, 65535));
    frame.push_back(crc[7:0]);
    frame.push_back(crc[15:8]);
    for (i = 0; i < frame.size() - drop_tail; i++) send_byte(frame[i]);
  endtask

  task automatic send_random_frame();
    int         pick;
    int         len;
    int         noise;
    int         drop;
    logic [7:0] id;
    byte_q_t    p;
    noise = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
    repeat (noise) send_byte(8'($urandom));
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      id  = flow_id;
      len = ($urandom_range(0, 7) == 0) ? random_length() : int'(mvr_pkg::FLOW_LEN);
    end else if (pick < 7) begin
      id  = dist_id;
      len = ($urandom_range(0, 7) == 0) ? random_length() : int'(mvr_pkg::DIST_LEN);
    end else begin
      id  = 8'($urandom);
      len = random_length();
    end
    p = random_payload(len);
    if (id == dist_id && len > 9 && $urandom_range(0, 3) == 0) begin
      p[8] = 8'hFF;
      p[9] = 8'hFF;
    end
    // A cut frame lets the parser swallow part of the next one.
    drop = ($urandom_range(0, 15) == 0) ? $urandom_range(1, len + 7) : 0;
    send_frame(id, p, $urandom_range(0, 7) == 0, drop);
  endtask

  task automatic test_directed_frames();
    byte_q_t p;
    idle_odds = 6;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7E);
    // Flow with the most negative x, the most positive y and full quality.
    p = random_payload(26);
    p[20] = 8'h00;
    p[21] = 8'h80;
    p[22] = 8'hFF;
    p[23] = 8'h7F;
    p[25] = 8'hFF;
    send_frame(flow_id, p, 1'b0, 0);
    p = random_payload(14);
    p[8] = 8'h34;
    p[9] = 8'h12;
    send_frame(dist_id, p, 1'b0, 0);
    p[8] = 8'hFF;
    p[9] = 8'hFF;
    send_frame(dist_id, p, 1'b0, 0);
    p.delete();
    send_frame(8'h00, p, 1'b0, 0);
    send_frame(flow_id, random_payload(26), 1'b1, 0);
    send_frame(dist_id, random_payload(13), 1'b0, 0);
    send_frame(flow_id, random_payload(30), 1'b0, 0);
    send_frame(mvr_pkg::START_BYTE, random_payload(5), 1'b1, 0);
    send_frame(dist_id, random_payload(14), 1'b0, 6);
    send_frame(flow_id, random_payload(26), 1'b0, 0);
    drain_results();
  endtask

  task automatic test_register_extremes();
    set_registers(8'h00, 8'hFF, 8'hFF, 8'h00);
    send_frame(8'h00, random_payload(26), 1'b0, 0);
    send_frame(8'hFF, random_payload(14), 1'b0, 0);
    send_frame(8'hFF, random_payload(26), 1'b0, 0);
    send_frame(mvr_pkg::FLOW_ID_RST, random_payload(26), 1'b0, 0);
    drain_results();
    // Both ids equal: the flow decode must take the frame.
    set_registers(8'h2A, 8'h2A, 8'h5C, 8'hC5);
    send_frame(8'h2A, random_payload(26), 1'b0, 0);
    send_frame(8'h2A, random_payload(14), 1'b0, 0);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int         phase_idx;
    int         phase_end;
    logic [7:0] shared_id;
    for (phase_idx = 0; phase_idx < 5; phase_idx++) begin
      case (phase_idx)
        0: begin
          set_registers(mvr_pkg::FLOW_ID_RST, mvr_pkg::DIST_ID_RST,
                        mvr_pkg::FLOW_EXTRA_RST, mvr_pkg::DIST_EXTRA_RST);
          idle_odds = 4;
        end
        1: begin
          set_registers(8'hFF, 8'h00, 8'h00, 8'hFF);
          idle_odds = 12;
        end
        2: begin
          shared_id = 8'($urandom);
          set_registers(shared_id, shared_id, 8'($urandom), 8'($urandom));
          idle_odds = 3;
        end
        3: begin
          set_registers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
          idle_odds = 8;
        end
        default: begin
          set_registers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
          idle_odds = 0;
        end
      endcase
      phase_end = bytes_parsed + RANDOM_BYTES / 5;
      while (bytes_parsed < phase_end) send_random_frame();
      drain_results();
    end
  endtask

  initial begin
    parse_phase  = mvr_pkg::PH_WAIT;
    pay_count    = 8'd0;
    pay_length   = 8'd0;
    crc_low_byte = 8'd0;
    crc_running  = mvr_pkg::CRC_INIT;
    flow_id      = mvr_pkg::FLOW_ID_RST;
    dist_id      = mvr_pkg::DIST_ID_RST;
    flow_extra   = mvr_pkg::FLOW_EXTRA_RST;
    dist_extra   = mvr_pkg::DIST_EXTRA_RST;
    foreach (header_q[i]) header_q[i] = 8'h00;
    foreach (capture[i]) capture[i] = 8'h00;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_frames();
    test_register_extremes();
    test_random_traffic();
    drain_results();
    if (error_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
